// ----- hdl/mfpc_pkg.sv -----
package mfpc_pkg;

    localparam int FRAME_BYTES_DEF = 1024;
    localparam int MAX_WIDTH_DEF   = 128;

    // request codes
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_REFRESH = 2'd1;
    localparam logic [1:0] REQ_FETCH   = 2'd2;

    // register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_OFFSET = 2'd2;

    localparam logic [7:0] RST_WIDTH  = 8'd96;
    localparam logic [6:0] RST_HEIGHT = 7'd16;
    localparam logic [2:0] RST_OFFSET = 3'd0;

    localparam logic [7:0] CMD_PAGE_RANGE = 8'h22;
    localparam logic [7:0] PAGE_START     = 8'h00;
    localparam logic [6:0] MAX_HEIGHT     = 7'd64;
    localparam int         ROWS_PER_PAGE  = 8;

    typedef struct packed {
        logic [1:0] req_type;
        logic [9:0] fb_addr;
        logic [7:0] fb_data;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       run_last;
        logic       frame_done;
    } out_word_t;

    typedef struct packed {
        logic [7:0] panel_width;
        logic [6:0] panel_height;
        logic [2:0] first_page;
    } cfg_t;

endpackage

// ----- hdl/mfpc_frame_ram.sv -----
// Single-port frame store; read data is registered, valid in the cycle after the read.
module mfpc_frame_ram #(
    parameter int DEPTH = mfpc_pkg::FRAME_BYTES_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/mfpc_cfg_regs.sv -----
// APB register file: panel geometry and first controller page.
module mfpc_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output mfpc_pkg::cfg_t      cfg
);

    logic [7:0] width_reg;
    logic [6:0] height_reg;
    logic [2:0] offset_reg;
    logic       wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= mfpc_pkg::RST_WIDTH;
            height_reg <= mfpc_pkg::RST_HEIGHT;
            offset_reg <= mfpc_pkg::RST_OFFSET;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                mfpc_pkg::REG_WIDTH:  width_reg  <= pwdata[7:0];
                mfpc_pkg::REG_HEIGHT: height_reg <= pwdata[6:0];
                mfpc_pkg::REG_OFFSET: offset_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            mfpc_pkg::REG_WIDTH:  prdata = {24'd0, width_reg};
            mfpc_pkg::REG_HEIGHT: prdata = {25'd0, height_reg};
            mfpc_pkg::REG_OFFSET: prdata = {29'd0, offset_reg};
            default:              prdata = 32'd0;
        endcase
    end

    assign cfg.panel_width  = width_reg;
    assign cfg.panel_height = height_reg;
    assign cfg.first_page   = offset_reg;

endmodule

// ----- hdl/mono_frame_page_column_packer_core.sv -----
// Monochrome frame store with page/column transpose. The host writes the
// 1-bpp row-major frame (bit 0 = leftmost pixel) one byte per write word,
// then sends a refresh word, which yields the three-byte page-range command
// (0x22, 0x00, end page) on m_data with is_data=0, and then one fetch word
// per display byte, each yielding one byte with is_data=1 in page-major,
// column order; frame_done marks the last byte of the frame. A fetch with
// no refresh armed gives nothing. After reset the store is zeroed by a
// clearing pass over every address, during which s_ready stays low (APB
// writes are taken throughout). A write is done at acceptance; a refresh
// is accepted and then emits the three header bytes; a fetch reads the
// single-port store eight times, one frame byte per row of the page, then
// emits the byte. One word is worked on at a time; the output register lets
// the next word in while the last result waits for m_ready.
module mono_frame_page_column_packer_core #(
    parameter int FRAME_BYTES = mfpc_pkg::FRAME_BYTES_DEF,
    parameter int MAX_WIDTH   = mfpc_pkg::MAX_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  mfpc_pkg::in_word_t    s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output mfpc_pkg::out_word_t   m_data,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int AW   = $clog2(FRAME_BYTES);        // store index
    localparam int CW   = $clog2(MAX_WIDTH);          // column cursor
    localparam int RAW  = $clog2(8 * MAX_WIDTH) + 1;  // computed read address
    localparam int WCAP = (MAX_WIDTH / 8) * 8;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HDR   = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    mfpc_pkg::cfg_t cfg;

    mfpc_cfg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---- effective geometry ----
    logic [7:0]  wm;     // width rounded down to x8
    logic [7:0]  w;      // width in use
    logic [6:0]  hm;
    logic [3:0]  pages;
    logic [11:0] fsize;

    always_comb begin
        wm = cfg.panel_width & 8'hF8;
        if (int'(wm) > WCAP) begin
            w = 8'(WCAP);
        end else begin
            w = wm;
        end
        hm = cfg.panel_height & 7'h78;
        if (hm > mfpc_pkg::MAX_HEIGHT) begin
            hm = mfpc_pkg::MAX_HEIGHT;
        end
        pages = 4'(hm >> 3);
        fsize = 12'(w) * 12'(pages);
    end

    // ---- control state ----
    logic [2:0]     state_reg, state_next;
    logic [AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [1:0]     hdr_idx_reg, hdr_idx_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic           active_reg, active_next;
    logic [2:0]     page_reg, page_next;
    logic [CW-1:0]  col_reg, col_next;
    logic           m_valid_reg, m_valid_next;

    // ---- payload ----
    logic [RAW-1:0]       addr_reg, addr_next;
    logic                 rd_ok_reg, rd_ok_next;
    logic [7:0]           bits_reg, bits_next;
    mfpc_pkg::out_word_t  out_reg, out_next;

    // store port
    logic           ram_en, ram_we;
    logic [AW-1:0]  ram_addr;
    logic [7:0]     ram_wdata, ram_rdata;

    mfpc_frame_ram #(.DEPTH(FRAME_BYTES)) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    logic s_fire;
    logic out_free;
    logic col_wrap;
    logic page_wrap;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign col_wrap  = (9'(col_reg) + 9'd1) >= 9'(w);
    assign page_wrap = (4'(page_reg) + 4'd1) >= pages;

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        hdr_idx_next = hdr_idx_reg;
        cnt_next     = cnt_reg;
        active_next  = active_reg;
        page_next    = page_reg;
        col_next     = col_reg;
        m_valid_next = m_valid_reg && !m_ready;
        addr_next    = addr_reg;
        rd_ok_next   = rd_ok_reg;
        bits_next    = bits_reg;
        out_next     = out_reg;
        ram_en       = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = AW'(addr_reg);
        ram_wdata    = s_data.fb_data;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = 8'd0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(FRAME_BYTES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (s_data.req_type)
                        mfpc_pkg::REQ_WRITE: begin
                            ram_addr = AW'(s_data.fb_addr);
                            if (12'(s_data.fb_addr) < fsize
                                && int'(s_data.fb_addr) < FRAME_BYTES) begin
                                ram_en = 1'b1;
                                ram_we = 1'b1;
                            end
                        end
                        mfpc_pkg::REQ_REFRESH: begin
                            page_next    = 3'd0;
                            col_next     = '0;
                            active_next  = (w != 8'd0) && (pages != 4'd0);
                            hdr_idx_next = 2'd0;
                            state_next   = ST_HDR;
                        end
                        mfpc_pkg::REQ_FETCH: begin
                            if (active_reg) begin
                                // first row of this page/column
                                addr_next  = RAW'(page_reg) * RAW'(w) + RAW'(col_reg >> 3);
                                cnt_next   = 4'd0;
                                state_next = ST_FETCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_HDR: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    out_next.is_data    = 1'b0;
                    out_next.frame_done = 1'b0;
                    out_next.run_last   = (hdr_idx_reg == 2'd2);
                    unique case (hdr_idx_reg)
                        2'd0:    out_next.out_byte = mfpc_pkg::CMD_PAGE_RANGE;
                        2'd1:    out_next.out_byte = mfpc_pkg::PAGE_START;
                        default: out_next.out_byte = 8'(cfg.first_page) + 8'(pages) - 8'd1;
                    endcase
                    if (hdr_idx_reg == 2'd2) begin
                        state_next = ST_IDLE;
                    end
                    hdr_idx_next = hdr_idx_reg + 2'd1;
                end
            end
            ST_FETCH: begin
                // read k issued at cnt=k, its data lands at cnt=k+1
                if (cnt_reg < 4'd8) begin
                    ram_en     = 1'b1;
                    rd_ok_next = 32'(addr_reg) < 32'(FRAME_BYTES);
                    addr_next  = addr_reg + RAW'(w >> 3);
                end
                if (cnt_reg != 4'd0) begin
                    bits_next = {ram_rdata[col_reg[2:0]] & rd_ok_reg, bits_reg[7:1]};
                end
                if (cnt_reg == 4'd8) begin
                    state_next = ST_EMIT;
                end
                cnt_next = cnt_reg + 4'd1;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    out_next.out_byte   = bits_reg;
                    out_next.is_data    = 1'b1;
                    out_next.run_last   = 1'b1;
                    out_next.frame_done = col_wrap && page_wrap;
                    if (col_wrap) begin
                        col_next = '0;
                        if (page_wrap) begin
                            active_next = 1'b0;
                            page_next   = 3'd0;
                        end else begin
                            page_next = page_reg + 3'd1;
                        end
                    end else begin
                        col_next = col_reg + CW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            hdr_idx_reg <= 2'd0;
            cnt_reg     <= 4'd0;
            active_reg  <= 1'b0;
            page_reg    <= 3'd0;
            col_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            hdr_idx_reg <= hdr_idx_next;
            cnt_reg     <= cnt_next;
            active_reg  <= active_next;
            page_reg    <= page_next;
            col_reg     <= col_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg  <= addr_next;
        rd_ok_reg <= rd_ok_next;
        bits_reg  <= bits_next;
        out_reg   <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    // frame_done only ever rides on a display byte
    a_done_is_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_done) |-> m_data.is_data)
        else $error("frame_done on a command byte");

    // a taken non-final header byte is followed at once by the next one
    a_hdr_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.run_last) |=> (m_valid && !m_data.is_data))
        else $error("header byte sequence broken");

    // eight reads then the byte goes out
    a_fetch_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH && cnt_reg == 4'd8) |=> (state_reg == ST_EMIT))
        else $error("fetch sequence did not end after eight reads");
`endif

endmodule

// ----- tb/mono_frame_page_column_packer_core_tb.sv -----
module mono_frame_page_column_packer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mfpc_pkg::*;

    // ------------------------------------------------------------------
    // Local constants
    // ------------------------------------------------------------------
    localparam logic [1:0] REQ_UNUSED  = 2'd3;     // request code the block ignores
    localparam int BYTE_BITS     = 8;
    localparam int MAX_W         = MAX_WIDTH_DEF & ~7;
    localparam int SETTLE_CYCLES = 24;             // longer than a fetch, covers no-result words
    localparam int LONG_HOLD     = 300;            // receiver hold-off for the fill-up test
    localparam int LIMIT_CYCLES  = 300000;
    localparam int PREDICT       = -1;             // table row checked by the predictor

    // Typed expectations simple enough to write by hand
    localparam out_word_t NO_WORD   = '0;
    localparam out_word_t HDR_CMD   = '{out_byte: CMD_PAGE_RANGE, is_data: 1'b0,
                                        run_last: 1'b0, frame_done: 1'b0};
    localparam out_word_t HDR_START = '{out_byte: PAGE_START, is_data: 1'b0,
                                        run_last: 1'b0, frame_done: 1'b0};
    // reset geometry 96x16, offset 0 -> end page 1
    localparam out_word_t HDR_END_RST = '{out_byte: 8'h01, is_data: 1'b0,
                                          run_last: 1'b1, frame_done: 1'b0};
    // first display byte of an all-zero store
    localparam out_word_t DATA_ZERO = '{out_byte: 8'h00, is_data: 1'b1,
                                        run_last: 1'b1, frame_done: 1'b0};

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [1:0] req;
        logic [9:0] addr;
        logic [7:0] data;
        int         n_typed;   // PREDICT, or number of typed result words
        out_word_t  e0;
        out_word_t  e1;
        out_word_t  e2;
    } dir_row_t;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_word_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_word_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mono_frame_page_column_packer_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Clock: 12 ns period
    // ------------------------------------------------------------------
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: config copy, frame image and read-out cursor
    // ------------------------------------------------------------------
    cfg_t       panel_cfg = '{panel_width: RST_WIDTH, panel_height: RST_HEIGHT,
                              first_page: RST_OFFSET};
    logic [7:0] frame_img [FRAME_BYTES_DEF] = '{default: 8'h00};
    bit         refresh_on = 1'b0;
    int         cur_page   = 0;
    int         cur_col    = 0;

    out_word_t  panel_q [$];       // display/command words still owed by the block

    int         errors       = 0;
    int         words_sent   = 0;
    int         words_seen   = 0;
    int         frames_seen  = 0;
    int         settings_cnt = 0;
    int         cycles       = 0;

    int         src_pct = 0;       // chance per cycle the sender stays idle
    int         snk_pct = 0;       // chance per cycle the receiver stalls
    int         hold_ask = 0;      // bumped by the sender to request a long hold-off
    int         hold_seen = 0;
    int         hold_left = 0;

    // empty geometries: zero width, zero height, both below eight
    logic [7:0] empty_w [3] = '{8'd0, 8'd8, 8'd7};
    logic [6:0] empty_h [3] = '{7'd16, 7'd0, 7'd5};
    logic [2:0] empty_o [3] = '{3'd0, 3'd0, 3'd7};

    dir_row_t dir_tab [16] = '{
        // fetch with nothing armed: no result
        '{REQ_FETCH,   10'd0,    8'h00, 0, NO_WORD, NO_WORD, NO_WORD},
        // unused code: ignored
        '{REQ_UNUSED,  10'd1023, 8'hFF, 0, NO_WORD, NO_WORD, NO_WORD},
        '{REQ_REFRESH, 10'd0,    8'h00, 3, HDR_CMD, HDR_START, HDR_END_RST},
        '{REQ_FETCH,   10'd0,    8'h00, 1, DATA_ZERO, NO_WORD, NO_WORD},
        '{REQ_WRITE,   10'd0,    8'hFF, 0, NO_WORD, NO_WORD, NO_WORD},
        '{REQ_WRITE,   10'd12,   8'h01, 0, NO_WORD, NO_WORD, NO_WORD},
        // last byte of the 96x16 frame
        '{REQ_WRITE,   10'd191,  8'h80, 0, NO_WORD, NO_WORD, NO_WORD},
        // just past the frame, and top of the store: both dropped
        '{REQ_WRITE,   10'd192,  8'hAA, 0, NO_WORD, NO_WORD, NO_WORD},
        '{REQ_WRITE,   10'd1023, 8'hFF, 0, NO_WORD, NO_WORD, NO_WORD},
        // refresh while one is active: header again, cursor back to 0,0
        '{REQ_REFRESH, 10'd1023, 8'hFF, 3, HDR_CMD, HDR_START, HDR_END_RST},
        '{REQ_FETCH,   10'd1023, 8'hFF, PREDICT, NO_WORD, NO_WORD, NO_WORD},
        '{REQ_FETCH,   10'd0,    8'h00, PREDICT, NO_WORD, NO_WORD, NO_WORD},
        // write into the frame being read out
        '{REQ_WRITE,   10'd1,    8'h55, 0, NO_WORD, NO_WORD, NO_WORD},
        '{REQ_FETCH,   10'd512,  8'h3C, PREDICT, NO_WORD, NO_WORD, NO_WORD},
        '{REQ_UNUSED,  10'd0,    8'h00, 0, NO_WORD, NO_WORD, NO_WORD},
        '{REQ_FETCH,   10'd255,  8'hC3, PREDICT, NO_WORD, NO_WORD, NO_WORD}
    };

    // ------------------------------------------------------------------
    // Geometry in use
    // ------------------------------------------------------------------
    function automatic int eff_width();
        int w;
        w = int'(panel_cfg.panel_width) & ~7;
        return (w > MAX_W) ? MAX_W : w;
    endfunction

    function automatic int eff_pages();
        int h;
        h = int'(panel_cfg.panel_height) & ~7;
        if (h > int'(MAX_HEIGHT))
            h = int'(MAX_HEIGHT);
        return h / ROWS_PER_PAGE;
    endfunction

    function automatic int frame_size();
        int n;
        n = eff_width() * eff_pages();
        return (n > FRAME_BYTES_DEF) ? FRAME_BYTES_DEF : n;
    endfunction

    // ------------------------------------------------------------------
    // Transpose predictor: advances the shadow for one accepted word and,
    // when queue_it is set, appends the words the block owes for it.
    // ------------------------------------------------------------------
    task automatic transpose_step(input in_word_t w, input bit queue_it);
        int         wd;
        int         pg;
        int         a;
        int         k;
        logic [7:0] bits;
        logic [7:0] src;
        logic       done;
        out_word_t  res;
        wd = eff_width();
        pg = eff_pages();
        case (w.req_type)
            REQ_WRITE: begin
                if (int'(w.fb_addr) < frame_size())
                    frame_img[w.fb_addr] = w.fb_data;
            end
            REQ_REFRESH: begin
                // end page wraps mod 256 on an empty geometry
                res = '{out_byte: 8'(int'(panel_cfg.first_page) + pg - 1),
                        is_data: 1'b0, run_last: 1'b1, frame_done: 1'b0};
                if (queue_it) begin
                    panel_q.push_back(HDR_CMD);
                    panel_q.push_back(HDR_START);
                    panel_q.push_back(res);
                end
                cur_page   = 0;
                cur_col    = 0;
                refresh_on = (wd != 0) && (pg != 0);
            end
            REQ_FETCH: begin
                if (refresh_on) begin
                    bits = 8'h00;
                    for (k = 0; k < ROWS_PER_PAGE; k++) begin
                        a    = cur_page * wd + (wd * k + cur_col) / BYTE_BITS;
                        src  = (a < FRAME_BYTES_DEF) ? frame_img[a] : 8'h00;
                        bits[k] = src[cur_col % BYTE_BITS];
                    end
                    done = 1'b0;
                    if (cur_col + 1 >= wd) begin
                        cur_col = 0;
                        if (cur_page + 1 >= pg) begin
                            done       = 1'b1;
                            refresh_on = 1'b0;
                            cur_page   = 0;
                        end else begin
                            cur_page++;
                        end
                    end else begin
                        cur_col++;
                    end
                    res = '{out_byte: bits, is_data: 1'b1, run_last: 1'b1, frame_done: done};
                    if (queue_it)
                        panel_q.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------
    function automatic in_word_t make_word(input logic [1:0] req);
        in_word_t w;
        w.req_type = req;
        w.fb_addr  = 10'($urandom);
        w.fb_data  = 8'($urandom);
        return w;
    endfunction

    // Mostly inside the frame, now and then anywhere in the 10-bit range
    function automatic in_word_t write_word(input int fsz);
        in_word_t w;
        w = make_word(REQ_WRITE);
        if (fsz > 0 && $urandom_range(0, 99) < 80)
            w.fb_addr = 10'($urandom_range(0, fsz - 1));
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Sender: called at a falling edge, returns at the falling edge after
    // the word was taken. Valid stays up with a fixed payload until then.
    // ------------------------------------------------------------------
    task automatic send_word(input in_word_t w, input bit predict);
        while ($urandom_range(0, 99) < src_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = w;
        do @(posedge aclk); while (!s_ready);
        transpose_step(w, predict);
        words_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic drain();
        while (panel_q.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Block idle: nothing owed and any no-result word has had time to finish
    task automatic settle();
        s_valid = 1'b0;
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin src_pct = 0;  snk_pct = 0;  end
            IDLE_SRC:  begin src_pct = 81; snk_pct = 0;  end
            IDLE_SNK:  begin src_pct = 0;  snk_pct = 81; end
            default:   begin src_pct = 26; snk_pct = 26; end
        endcase
    endtask

    // ------------------------------------------------------------------
    // APB: setup + access write, then a readback of the same register
    // ------------------------------------------------------------------
    task automatic reg_write(input logic [1:0] idx, input logic [7:0] value);
        logic [31:0] rd;
        logic [31:0] want;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = 32'(value);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_WIDTH:  panel_cfg.panel_width  = value;
            REG_HEIGHT: panel_cfg.panel_height = value[6:0];
            REG_OFFSET: panel_cfg.first_page   = value[2:0];
            default: ;
        endcase
        @(negedge aclk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        case (idx)
            REG_WIDTH:  want = 32'(panel_cfg.panel_width);
            REG_HEIGHT: want = 32'(panel_cfg.panel_height);
            default:    want = 32'(panel_cfg.first_page);
        endcase
        if (rd !== want) begin
            $display("%0t ns: readback reg %0d expected %08h actual %08h",
                     $time, idx, want, rd);
            errors++;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_config(input logic [7:0] w, input logic [6:0] h, input logic [2:0] o);
        reg_write(REG_WIDTH,  w);
        reg_write(REG_HEIGHT, 8'(h));
        reg_write(REG_OFFSET, 8'(o));
        settings_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly whole frames (writes, refresh, fetches to the
    // end, with a little noise mixed in), the rest loose random words.
    // ------------------------------------------------------------------
    task automatic run_random(input int n_words);
        int sent;
        int k;
        int fsz;
        bit restarted;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 99) < 70) begin
                fsz = frame_size();
                repeat ($urandom_range(1, 8)) begin
                    send_word(write_word(fsz), 1'b1);
                    sent++;
                end
                send_word(make_word(REQ_REFRESH), 1'b1);
                sent++;
                restarted = 1'b0;
                while (refresh_on) begin
                    k = $urandom_range(0, 99);
                    if (k < 3) begin
                        send_word(make_word(REQ_UNUSED), 1'b1);
                    end else if (k < 5 && !restarted) begin
                        restarted = 1'b1;
                        send_word(make_word(REQ_REFRESH), 1'b1);
                    end else if (k < 10) begin
                        send_word(write_word(fsz), 1'b1);
                    end else begin
                        send_word(make_word(REQ_FETCH), 1'b1);
                    end
                    sent++;
                end
                // stray fetch after the frame ended
                if ($urandom_range(0, 99) < 30) begin
                    send_word(make_word(REQ_FETCH), 1'b1);
                    sent++;
                end
            end else begin
                send_word(make_word(2'($urandom_range(0, 3))), 1'b1);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready changes on the falling edge. A hold-off request from
    // the sender keeps ready low until the LONG_HOLD countdown runs out.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= snk_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checker: every word taken off m_data against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            words_seen++;
            if (m_data.frame_done)
                frames_seen++;
            if (panel_q.size() == 0) begin
                $display("%0t ns: unexpected word byte %02h dc %0b last %0b done %0b",
                         $time, m_data.out_byte, m_data.is_data, m_data.run_last,
                         m_data.frame_done);
                errors++;
            end else begin
                want = panel_q.pop_front();
                if (m_data.out_byte !== want.out_byte) begin
                    $display("%0t ns: out_byte expected %02h actual %02h",
                             $time, want.out_byte, m_data.out_byte);
                    errors++;
                end
                if (m_data.is_data !== want.is_data) begin
                    $display("%0t ns: is_data expected %0b actual %0b",
                             $time, want.is_data, m_data.is_data);
                    errors++;
                end
                if (m_data.run_last !== want.run_last) begin
                    $display("%0t ns: run_last expected %0b actual %0b",
                             $time, want.run_last, m_data.run_last);
                    errors++;
                end
                if (m_data.frame_done !== want.frame_done) begin
                    $display("%0t ns: frame_done expected %0b actual %0b",
                             $time, want.frame_done, m_data.frame_done);
                    errors++;
                end
            end
        end
    end

    // Watchdog; budget includes the post-reset clearing pass
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("%0t ns: timeout, %0d words still owed", $time, panel_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        dir_row_t   row;
        int         i;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table at reset geometry (96x16, offset 0), no idling.
        // The first word waits out the store clearing pass on s_ready.
        // The refresh is left running into the next geometry.
        set_idling(IDLE_NONE);
        for (i = 0; i < $size(dir_tab); i++) begin
            row = dir_tab[i];
            send_word('{req_type: row.req, fb_addr: row.addr, fb_data: row.data},
                      row.n_typed == PREDICT);
            if (row.n_typed > 0) panel_q.push_back(row.e0);
            if (row.n_typed > 1) panel_q.push_back(row.e1);
            if (row.n_typed > 2) panel_q.push_back(row.e2);
        end

        // Smallest panel, top page offset; sender mostly idle
        settle();
        set_idling(IDLE_SRC);
        set_config(8'd8, 7'd8, 3'd7);
        run_random(12);

        // Largest panel: fill part of the store, then read only part of the
        // frame so the refresh is still running at the next config change
        settle();
        set_idling(IDLE_NONE);
        set_config(8'd128, 7'd64, 3'd0);
        repeat (10) send_word(write_word(frame_size()), 1'b1);
        send_word('{req_type: REQ_WRITE, fb_addr: 10'd1023, fb_data: 8'hA5}, 1'b1);
        send_word(make_word(REQ_REFRESH), 1'b1);
        repeat (16) send_word(make_word(REQ_FETCH), 1'b1);

        // Geometry shrinks under the running refresh; receiver mostly stalled
        settle();
        set_idling(IDLE_SNK);
        set_config(8'd16, 7'd8, 3'd3);
        while (refresh_on)
            send_word(make_word(REQ_FETCH), 1'b1);
        run_random(20);

        // Width and height past the caps; both sides idle now and then
        settle();
        set_idling(IDLE_BOTH);
        set_config(8'd255, 7'd8, 3'd1);
        repeat (3) send_word(write_word(frame_size()), 1'b1);
        send_word(make_word(REQ_REFRESH), 1'b1);
        repeat (8) send_word(make_word(REQ_FETCH), 1'b1);
        settle();
        set_config(8'd24, 7'd127, 3'd4);
        repeat (6) send_word(write_word(frame_size()), 1'b1);
        send_word(make_word(REQ_REFRESH), 1'b1);
        repeat (6) send_word(make_word(REQ_FETCH), 1'b1);
        send_word(make_word(REQ_REFRESH), 1'b1);

        // Empty geometries: header only (end page may wrap), nothing armed
        for (i = 0; i < 3; i++) begin
            settle();
            set_idling(IDLE_NONE);
            set_config(empty_w[i], empty_h[i], empty_o[i]);
            send_word(make_word(REQ_REFRESH), 1'b1);
            send_word(make_word(REQ_FETCH), 1'b1);
            send_word(make_word(REQ_WRITE), 1'b1);
            send_word(make_word(REQ_FETCH), 1'b1);
        end

        // Widths that are not multiples of eight. Receiver holds off for a
        // long stretch while the sender keeps offering, so the block backs
        // up into s_ready; then the sender waits for everything to drain.
        settle();
        set_idling(IDLE_BOTH);
        set_config(8'd13, 7'd21, 3'd2);
        hold_ask++;
        send_word(make_word(REQ_REFRESH), 1'b1);
        repeat (23) send_word(make_word(2'($urandom_range(0, 2))), 1'b1);
        drain();
        run_random(16);

        // Tallest panel at the narrowest width, read out to frame_done
        settle();
        set_idling(IDLE_SNK);
        set_config(8'd8, 7'd64, 3'd7);
        repeat (4) send_word(write_word(frame_size()), 1'b1);
        send_word(make_word(REQ_REFRESH), 1'b1);
        while (refresh_on)
            send_word(make_word(REQ_FETCH), 1'b1);

        // A couple of random small geometries
        for (i = 0; i < 2; i++) begin
            settle();
            set_idling(IDLE_SRC);
            set_config(8'($urandom_range(1, 2) * 8), 7'($urandom_range(1, 2) * 8),
                       3'($urandom_range(0, 7)));
            run_random(8);
        end

        settle();
        $display("Run: %0d words sent over %0d register settings plus reset values,",
                 words_sent, settings_cnt);
        $display("     %0d result words checked, %0d complete frames read out",
                 words_seen, frames_seen);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/mfpc_pkg.sv
hdl/mfpc_frame_ram.sv
hdl/mfpc_cfg_regs.sv
hdl/mono_frame_page_column_packer_core.sv
tb/mono_frame_page_column_packer_core_tb.sv
